[sv/dnsrp_pkg.sv]
package dnsrp_pkg;

  // Input request: one byte of the message
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // Result request: address record or message summary
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] message_id;
    logic [3:0]  response_code;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [31:0] time_to_live;
    logic [1:0]  status;
    logic [15:0] address_count;
    logic        end_of_run;
  } out_t;

  // Results produced by one byte, oldest first
  typedef struct packed {
    logic [1:0] count;
    out_t       res0;
    out_t       res1;
  } emit_t;

  // Result kinds
  localparam logic [1:0] KindIpv4    = 2'd0;
  localparam logic [1:0] KindIpv6    = 2'd1;
  localparam logic [1:0] KindSummary = 2'd2;

  // Summary status codes
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusTruncated = 2'd1;
  localparam logic [1:0] StatusBad       = 2'd2;
  localparam logic [1:0] StatusRcode     = 2'd3;

  // Record types and name pointer limit
  localparam logic [15:0] RecTypeA    = 16'd1;
  localparam logic [15:0] RecTypeAaaa = 16'd28;
  localparam logic [7:0]  LabelMax    = 8'd63;

  // Output queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

endpackage

[sv/dns_response_record_parser_unit.sv]
// DNS response parser: takes one message byte per cycle and walks header,
// questions and answer records, emitting an address result for each A or
// AAAA answer and a summary (status, largest TTL, address count) on the byte
// flagged last. Each byte is parsed in the cycle it is accepted, so the input
// runs at one byte per clock; its results are written into a four-entry output
// queue. A byte can cause two results (an address plus the summary); these
// drain from the queue one per cycle while the output is ready, and the input
// stalls only when fewer than two queue slots are free.
module dns_response_record_parser_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dnsrp_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dnsrp_pkg::out_t out_data_o
);

  logic             in_fire;
  dnsrp_pkg::emit_t emit;

  assign in_fire = in_valid_i && in_ready_o;

  // Parse each accepted byte
  dnsrp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .req_i  (in_data_i),
    .emit_o (emit)
  );

  // Queue results toward the output
  dnsrp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/dnsrp_parse.sv]
module dnsrp_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  dnsrp_pkg::in_t req_i,
  output dnsrp_pkg::emit_t emit_o
);

  localparam logic [3:0] PhHeader = 4'd0;
  localparam logic [3:0] PhQname  = 4'd1;
  localparam logic [3:0] PhQptr   = 4'd2;
  localparam logic [3:0] PhQfixed = 4'd3;
  localparam logic [3:0] PhAname  = 4'd4;
  localparam logic [3:0] PhAptr   = 4'd5;
  localparam logic [3:0] PhAfixed = 4'd6;
  localparam logic [3:0] PhRdata  = 4'd7;
  localparam logic [3:0] PhDone   = 4'd8;
  localparam logic [3:0] PhBad    = 4'd9;
  localparam logic [3:0] PhRcode  = 4'd10;

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  fbi_q, fbi_d;
  logic [15:0] id_q, id_d;
  logic [15:0] flags_q, flags_d;
  logic [15:0] qleft_q, qleft_d;
  logic [15:0] aleft_q, aleft_d;
  logic [5:0]  label_q, label_d;
  logic [15:0] rtype_q, rtype_d;
  logic [31:0] rttl_q, rttl_d;
  logic [31:0] maxttl_q, maxttl_d;
  logic [15:0] rdleft_q, rdleft_d;
  logic [63:0] acc_hi_q, acc_hi_d;
  logic [63:0] acc_lo_q, acc_lo_d;
  logic [4:0]  abi_q, abi_d;
  logic [15:0] naddr_q, naddr_d;

  logic [7:0]  b;
  logic        fin;
  logic        is_a, is_aaaa;
  logic [1:0]  sum_status;
  dnsrp_pkg::out_t rec_res, sum_res;

  assign b       = req_i.data_byte;
  assign is_a    = (rtype_q == dnsrp_pkg::RecTypeA);
  assign is_aaaa = (rtype_q == dnsrp_pkg::RecTypeAaaa);

  // Next parse state and results for one byte
  always_comb begin
    phase_d  = phase_q;
    fbi_d    = fbi_q;
    id_d     = id_q;
    flags_d  = flags_q;
    qleft_d  = qleft_q;
    aleft_d  = aleft_q;
    label_d  = label_q;
    rtype_d  = rtype_q;
    rttl_d   = rttl_q;
    maxttl_d = maxttl_q;
    rdleft_d = rdleft_q;
    acc_hi_d = acc_hi_q;
    acc_lo_d = acc_lo_q;
    abi_d    = abi_q;
    naddr_d  = naddr_q;
    fin      = 1'b0;
    rec_res  = '0;
    sum_res  = '0;
    sum_status = dnsrp_pkg::StatusTruncated;
    emit_o   = '0;

    if (fire_i) begin
      case (phase_q)
        PhHeader: begin
          if (fbi_q inside {[4'd0:4'd1]}) id_d = {id_q[7:0], b};
          else if (fbi_q inside {[4'd2:4'd3]}) flags_d = {flags_q[7:0], b};
          else if (fbi_q inside {[4'd4:4'd5]}) qleft_d = {qleft_q[7:0], b};
          else if (fbi_q inside {[4'd6:4'd7]}) aleft_d = {aleft_q[7:0], b};
          if (fbi_q >= 4'd11) begin
            fbi_d   = '0;
            label_d = '0;
            if (!flags_q[15] || qleft_q == 16'd0) phase_d = PhBad;
            else if (flags_q[3:0] != 4'd0) phase_d = PhRcode;
            else phase_d = PhQname;
          end else begin
            fbi_d = fbi_q + 4'd1;
          end
        end
        PhQname, PhAname: begin
          if (label_q != 6'd0) begin
            label_d = label_q - 6'd1;
          end else if (b == 8'd0) begin
            phase_d = (phase_q == PhQname) ? PhQfixed : PhAfixed;
            fbi_d   = '0;
          end else if (b > dnsrp_pkg::LabelMax) begin
            phase_d = (phase_q == PhQname) ? PhQptr : PhAptr;
          end else begin
            label_d = b[5:0];
          end
        end
        PhQptr, PhAptr: begin
          phase_d = (phase_q == PhQptr) ? PhQfixed : PhAfixed;
          fbi_d   = '0;
        end
        PhQfixed: begin
          if (fbi_q >= 4'd3) begin
            qleft_d = qleft_q - 16'd1;
            label_d = '0;
            if (qleft_d != 16'd0) phase_d = PhQname;
            else phase_d = (aleft_q == 16'd0) ? PhDone : PhAname;
          end else begin
            fbi_d = fbi_q + 4'd1;
          end
        end
        PhAfixed: begin
          if (fbi_q inside {[4'd0:4'd1]}) rtype_d = {rtype_q[7:0], b};
          else if (fbi_q inside {[4'd4:4'd7]}) rttl_d = {rttl_q[23:0], b};
          else if (fbi_q >= 4'd8) rdleft_d = {rdleft_q[7:0], b};
          if (fbi_q >= 4'd9) begin
            if (rttl_q > maxttl_q) maxttl_d = rttl_q;
            acc_hi_d = '0;
            acc_lo_d = '0;
            abi_d    = '0;
            fbi_d    = '0;
            if (rdleft_d == 16'd0) fin = 1'b1;
            else phase_d = PhRdata;
          end else begin
            fbi_d = fbi_q + 4'd1;
          end
        end
        PhRdata: begin
          // Place the byte into its address lane
          if (is_a && abi_q < 5'd4)
            acc_lo_d[{1'b0, ~abi_q[1:0], 3'b000} +: 8] = acc_lo_q[{1'b0, ~abi_q[1:0], 3'b000} +: 8] | b;
          else if (is_aaaa && abi_q < 5'd8)
            acc_hi_d[{~abi_q[2:0], 3'b000} +: 8] = acc_hi_q[{~abi_q[2:0], 3'b000} +: 8] | b;
          else if (is_aaaa && abi_q < 5'd16)
            acc_lo_d[{~abi_q[2:0], 3'b000} +: 8] = acc_lo_q[{~abi_q[2:0], 3'b000} +: 8] | b;
          if (abi_q < 5'd16) abi_d = abi_q + 5'd1;
          rdleft_d = rdleft_q - 16'd1;
          if (rdleft_d == 16'd0) fin = 1'b1;
        end
        default: begin
        end
      endcase

      // Close the answer record, emit an address for A and AAAA
      if (fin) begin
        if (is_a || is_aaaa) begin
          naddr_d                = naddr_q + 16'd1;
          rec_res.kind           = is_a ? dnsrp_pkg::KindIpv4 : dnsrp_pkg::KindIpv6;
          rec_res.message_id     = id_q;
          rec_res.response_code  = flags_q[3:0];
          rec_res.address_high   = is_aaaa ? acc_hi_d : 64'd0;
          rec_res.address_low    = acc_lo_d;
          rec_res.time_to_live   = rttl_q;
          rec_res.status         = dnsrp_pkg::StatusOk;
          rec_res.address_count  = naddr_d;
          rec_res.end_of_run     = 1'b1;
          emit_o.count           = 2'd1;
          emit_o.res0            = rec_res;
        end
        aleft_d = aleft_q - 16'd1;
        phase_d = (aleft_d == 16'd0) ? PhDone : PhAname;
        label_d = '0;
      end

      // Summarize on the last byte and return to reset state
      if (req_i.last_byte) begin
        case (phase_d)
          PhDone:  sum_status = dnsrp_pkg::StatusOk;
          PhBad:   sum_status = dnsrp_pkg::StatusBad;
          PhRcode: sum_status = dnsrp_pkg::StatusRcode;
          default: sum_status = dnsrp_pkg::StatusTruncated;
        endcase
        sum_res.kind          = dnsrp_pkg::KindSummary;
        sum_res.message_id    = id_d;
        sum_res.response_code = flags_d[3:0];
        sum_res.time_to_live  = maxttl_d;
        sum_res.status        = sum_status;
        sum_res.address_count = naddr_d;
        sum_res.end_of_run    = 1'b1;
        if (emit_o.count != 2'd0) begin
          emit_o.res0.end_of_run = 1'b0;
          emit_o.res1  = sum_res;
          emit_o.count = 2'd2;
        end else begin
          emit_o.res0  = sum_res;
          emit_o.count = 2'd1;
        end
        phase_d  = PhHeader;
        fbi_d    = '0;
        id_d     = '0;
        flags_d  = '0;
        qleft_d  = '0;
        aleft_d  = '0;
        label_d  = '0;
        rtype_d  = '0;
        rttl_d   = '0;
        maxttl_d = '0;
        rdleft_d = '0;
        acc_hi_d = '0;
        acc_lo_d = '0;
        abi_d    = '0;
        naddr_d  = '0;
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      fbi_q    <= '0;
      id_q     <= '0;
      flags_q  <= '0;
      qleft_q  <= '0;
      aleft_q  <= '0;
      label_q  <= '0;
      rtype_q  <= '0;
      rttl_q   <= '0;
      maxttl_q <= '0;
      rdleft_q <= '0;
      acc_hi_q <= '0;
      acc_lo_q <= '0;
      abi_q    <= '0;
      naddr_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      fbi_q    <= fbi_d;
      id_q     <= id_d;
      flags_q  <= flags_d;
      qleft_q  <= qleft_d;
      aleft_q  <= aleft_d;
      label_q  <= label_d;
      rtype_q  <= rtype_d;
      rttl_q   <= rttl_d;
      maxttl_q <= maxttl_d;
      rdleft_q <= rdleft_d;
      acc_hi_q <= acc_hi_d;
      acc_lo_q <= acc_lo_d;
      abi_q    <= abi_d;
      naddr_q  <= naddr_d;
    end
  end

endmodule

[sv/dnsrp_out_fifo.sv]
module dnsrp_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dnsrp_pkg::emit_t emit_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dnsrp_pkg::out_t  out_data_o
);

  dnsrp_pkg::out_t mem_q [dnsrp_pkg::FifoDepth];

  logic [dnsrp_pkg::FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [dnsrp_pkg::FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [dnsrp_pkg::FifoCntW-1:0] cnt_q, cnt_d;
  logic [dnsrp_pkg::FifoPtrW-1:0] wr_ptr_nx;
  logic                           pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign wr_ptr_nx   = wr_ptr_q + dnsrp_pkg::FifoPtrW'(1);

  // Accept a byte only while two result slots are free
  assign room_o = (cnt_q <= dnsrp_pkg::FifoCntW'(dnsrp_pkg::FifoDepth - 2));

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q + dnsrp_pkg::FifoPtrW'(emit_i.count);
    rd_ptr_d = pop ? rd_ptr_q + dnsrp_pkg::FifoPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + dnsrp_pkg::FifoCntW'(emit_i.count)
               - dnsrp_pkg::FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store results in order
  always_ff @(posedge clk_i) begin
    if (emit_i.count != 2'd0) mem_q[wr_ptr_q] <= emit_i.res0;
    if (emit_i.count == 2'd2) mem_q[wr_ptr_nx] <= emit_i.res1;
  end

endmodule

[sim/tb_dns_response_record_parser_unit.sv]
module tb_dns_response_record_parser_unit;

  localparam int unsigned   MaxShown     = 10;
  localparam int unsigned   StallLimit   = 2000;
  localparam int unsigned   HoldCycles   = 300;
  localparam int unsigned   EndDrain     = 20;
  localparam int unsigned   PhaseBytes   = 110;
  localparam logic [15:0]   RecTypeCname = 16'd5;
  localparam logic [15:0]   FlagsAnswer  = 16'h8180;

  // Parse position inside the message
  typedef enum logic [3:0] {
    SecHeader, SecQname, SecQptr, SecQfixed, SecAname, SecAptr,
    SecAfixed, SecRdata, SecDone, SecNotResp, SecRcode
  } parse_sect_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dnsrp_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dnsrp_pkg::out_t out_data;

  dns_response_record_parser_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predicted parse state
  parse_sect_e sect = SecHeader;
  logic [3:0]  fld = '0;
  logic [15:0] p_id = '0, p_flags = '0, p_qd = '0, p_an = '0;
  logic [5:0]  p_label = '0;
  logic [15:0] p_type = '0, p_rdlen = '0, p_addr_cnt = '0;
  logic [31:0] p_ttl = '0, p_ttl_max = '0;
  logic [63:0] p_addr_hi = '0, p_addr_lo = '0;
  logic [4:0]  p_addr_pos = '0;
  dnsrp_pkg::out_t addr_rec;
  bit          have_addr;

  dnsrp_pkg::out_t records_due[$];
  logic [7:0]  msg_bytes[$];

  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned msgs_sent = 0;
  int unsigned addr_seen = 0;
  int unsigned summary_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Parse predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_parse();
    sect = SecHeader;
    fld = '0;
    p_id = '0;
    p_flags = '0;
    p_qd = '0;
    p_an = '0;
    p_label = '0;
    p_type = '0;
    p_ttl = '0;
    p_ttl_max = '0;
    p_rdlen = '0;
    p_addr_hi = '0;
    p_addr_lo = '0;
    p_addr_pos = '0;
    p_addr_cnt = '0;
  endfunction

  // Append one expected result at the tail of the pending list
  function automatic void queue_result(dnsrp_pkg::out_t r);
    records_due.insert(records_due.size(), r);
  endfunction

  function automatic dnsrp_pkg::out_t make_record(logic [1:0] kind, logic [63:0] hi,
                                                  logic [63:0] lo, logic [31:0] ttl,
                                                  logic [1:0] status, logic eor);
    dnsrp_pkg::out_t r;
    r.kind          = kind;
    r.message_id    = p_id;
    r.response_code = p_flags[3:0];
    r.address_high  = hi;
    r.address_low   = lo;
    r.time_to_live  = ttl;
    r.status        = status;
    r.address_count = p_addr_cnt;
    r.end_of_run    = eor;
    return r;
  endfunction

  // Skip label text, stop at a zero byte or at a pointer
  function automatic void walk_name(logic [7:0] b, parse_sect_e ptr_sect,
                                    parse_sect_e fixed_sect);
    if (p_label != 0) begin
      p_label--;
    end else if (b == 8'd0) begin
      sect = fixed_sect;
      fld = '0;
    end else if (b > dnsrp_pkg::LabelMax) begin
      sect = ptr_sect;
    end else begin
      p_label = b[5:0];
    end
  endfunction

  // Close one answer record, emitting its address when it is A or AAAA
  function automatic void close_answer();
    if (p_type == dnsrp_pkg::RecTypeA || p_type == dnsrp_pkg::RecTypeAaaa) begin
      p_addr_cnt++;
      if (p_type == dnsrp_pkg::RecTypeA) begin
        addr_rec = make_record(dnsrp_pkg::KindIpv4, 64'd0, p_addr_lo, p_ttl,
                               dnsrp_pkg::StatusOk, 1'b1);
      end else begin
        addr_rec = make_record(dnsrp_pkg::KindIpv6, p_addr_hi, p_addr_lo, p_ttl,
                               dnsrp_pkg::StatusOk, 1'b1);
      end
      have_addr = 1'b1;
    end
    p_an--;
    if (p_an == 0) begin
      sect = SecDone;
    end else begin
      sect = SecAname;
    end
    p_label = '0;
  endfunction

  // Advance the parse by one accepted byte and queue the records it produces
  function automatic void predict_records(dnsrp_pkg::in_t it);
    logic [7:0]  b;
    int unsigned i;
    logic [1:0]  st;
    b = it.data_byte;
    have_addr = 1'b0;
    case (sect)
      SecHeader: begin
        i = 32'(fld);
        if (i < 2) p_id = {p_id[7:0], b};
        else if (i < 4) p_flags = {p_flags[7:0], b};
        else if (i < 6) p_qd = {p_qd[7:0], b};
        else if (i < 8) p_an = {p_an[7:0], b};
        if (i >= 11) begin
          fld = '0;
          p_label = '0;
          if (!p_flags[15] || p_qd == 0) sect = SecNotResp;
          else if (p_flags[3:0] != 0) sect = SecRcode;
          else sect = SecQname;
        end else begin
          fld = 4'(i + 1);
        end
      end
      SecQname: walk_name(b, SecQptr, SecQfixed);
      SecQptr: begin
        sect = SecQfixed;
        fld = '0;
      end
      SecQfixed: begin
        if (fld >= 3) begin
          p_qd--;
          p_label = '0;
          if (p_qd != 0) sect = SecQname;
          else if (p_an == 0) sect = SecDone;
          else sect = SecAname;
        end else begin
          fld++;
        end
      end
      SecAname: walk_name(b, SecAptr, SecAfixed);
      SecAptr: begin
        sect = SecAfixed;
        fld = '0;
      end
      SecAfixed: begin
        i = 32'(fld);
        if (i < 2) p_type = {p_type[7:0], b};
        else if (i >= 4 && i < 8) p_ttl = {p_ttl[23:0], b};
        else if (i >= 8) p_rdlen = {p_rdlen[7:0], b};
        if (i >= 9) begin
          if (p_ttl > p_ttl_max) p_ttl_max = p_ttl;
          p_addr_hi = '0;
          p_addr_lo = '0;
          p_addr_pos = '0;
          fld = '0;
          if (p_rdlen == 0) close_answer();
          else sect = SecRdata;
        end else begin
          fld = 4'(i + 1);
        end
      end
      SecRdata: begin
        i = 32'(p_addr_pos);
        if (p_type == dnsrp_pkg::RecTypeA && i < 4) begin
          p_addr_lo |= 64'(b) << (8 * (3 - i));
        end else if (p_type == dnsrp_pkg::RecTypeAaaa && i < 8) begin
          p_addr_hi |= 64'(b) << (8 * (7 - i));
        end else if (p_type == dnsrp_pkg::RecTypeAaaa && i < 16) begin
          p_addr_lo |= 64'(b) << (8 * (15 - i));
        end
        if (i < 16) p_addr_pos = 5'(i + 1);
        p_rdlen--;
        if (p_rdlen == 0) close_answer();
      end
      default: ;
    endcase

    if (it.last_byte) begin
      case (sect)
        SecDone:    st = dnsrp_pkg::StatusOk;
        SecNotResp: st = dnsrp_pkg::StatusBad;
        SecRcode:   st = dnsrp_pkg::StatusRcode;
        default:    st = dnsrp_pkg::StatusTruncated;
      endcase
      if (have_addr) begin
        addr_rec.end_of_run = 1'b0;
        queue_result(addr_rec);
      end
      queue_result(make_record(dnsrp_pkg::KindSummary, 64'd0, 64'd0, p_ttl_max, st, 1'b1));
      clear_parse();
    end else if (have_addr) begin
      queue_result(addr_rec);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= MaxShown) begin
      $display("mismatch in %s: expected %h, got %h", what, want, got);
    end
  endtask

  task automatic check_record(dnsrp_pkg::out_t got);
    dnsrp_pkg::out_t want;
    if (records_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxShown) $display("result with nothing pending: %h", got);
    end else begin
      want = records_due.pop_front();
      if (want.kind == dnsrp_pkg::KindSummary) summary_seen++;
      else addr_seen++;
      if (got.kind !== want.kind) report("kind", 64'(want.kind), 64'(got.kind));
      if (got.message_id !== want.message_id) report("message_id", 64'(want.message_id),
                                                     64'(got.message_id));
      if (got.response_code !== want.response_code) report("response_code",
                                                           64'(want.response_code),
                                                           64'(got.response_code));
      if (got.address_high !== want.address_high) report("address_high", want.address_high,
                                                         got.address_high);
      if (got.address_low !== want.address_low) report("address_low", want.address_low,
                                                       got.address_low);
      if (got.time_to_live !== want.time_to_live) report("time_to_live",
                                                         64'(want.time_to_live),
                                                         64'(got.time_to_live));
      if (got.status !== want.status) report("status", 64'(want.status), 64'(got.status));
      if (got.address_count !== want.address_count) report("address_count",
                                                           64'(want.address_count),
                                                           64'(got.address_count));
      if (got.end_of_run !== want.end_of_run) report("end_of_run", 64'(want.end_of_run),
                                                     64'(got.end_of_run));
    end
  endtask

  // Check outgoing results first, then predict from the accepted request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_record(out_data);
      if (in_valid && in_ready) predict_records(in_data);
    end
  end

  // Drive output ready: random stalls, or a long hold when asked
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      out_ready <= 1'b0;
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // End the run when no request moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("no progress for %0d cycles, %0d results pending", quiet_cycles,
                 records_due.size());
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Message building and sending
  // ---------------------------------------------------------------------------

  // Append one byte at the tail of the message under construction
  function automatic void add_byte(logic [7:0] v);
    msg_bytes.insert(msg_bytes.size(), v);
  endfunction

  function automatic void put16(logic [15:0] v);
    add_byte(v[15:8]);
    add_byte(v[7:0]);
  endfunction

  function automatic void put32(logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endfunction

  function automatic void put_header(logic [15:0] id, logic [15:0] flags,
                                     logic [15:0] qd, logic [15:0] an);
    put16(id);
    put16(flags);
    put16(qd);
    put16(an);
    put32($urandom);
  endfunction

  // Labels with random text, closed by a zero byte or by a two-byte pointer
  function automatic void put_name(int unsigned labels, logic [7:0] tail);
    int unsigned len;
    repeat (labels) begin
      len = ($urandom_range(9) == 0) ? 32'(dnsrp_pkg::LabelMax) : $urandom_range(1, 8);
      add_byte(8'(len));
      repeat (len) add_byte(8'($urandom));
    end
    add_byte(tail);
    if (tail != 8'd0) add_byte(8'($urandom));
  endfunction

  function automatic logic [7:0] rand_tail();
    return $urandom_range(1) ? 8'($urandom_range(64, 255)) : 8'd0;
  endfunction

  function automatic void put_question(logic [7:0] tail);
    put_name($urandom_range(0, 2), tail);
    put32($urandom);
  endfunction

  function automatic void put_answer(logic [15:0] rtype, logic [31:0] ttl, int unsigned rdlen);
    put_name($urandom_range(0, 2), rand_tail());
    put16(rtype);
    put16(16'($urandom));
    put32(ttl);
    put16(16'(rdlen));
    repeat (rdlen) add_byte(8'($urandom));
  endfunction

  function automatic void cut_message(int unsigned keep);
    while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
  endfunction

  // Mostly well-formed responses with random content; some noise and broken ones
  function automatic void gen_random_message();
    int unsigned pick, qd, an, k, rsel, rdlen;
    logic [15:0] flags, rtype;
    logic [31:0] ttl;
    msg_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 40)) add_byte(8'($urandom));
      return;
    end
    qd = $urandom_range(1, 2);
    an = $urandom_range(0, 3);
    flags = 16'($urandom);
    flags[15] = 1'b1;
    flags[3:0] = 4'd0;
    if (pick < 14) begin
      if ($urandom_range(1)) flags[15] = 1'b0;
      else qd = 0;
    end else if (pick < 20) begin
      flags[3:0] = 4'($urandom_range(1, 15));
    end
    put_header(16'($urandom), flags, 16'(qd), 16'(an));
    repeat ((qd == 0) ? 1 : qd) put_question(rand_tail());
    for (k = 0; k < an; k++) begin
      rsel = $urandom_range(99);
      case ($urandom_range(9))
        0:       ttl = 32'd0;
        1:       ttl = 32'hFFFF_FFFF;
        default: ttl = $urandom;
      endcase
      if (rsel < 40) begin
        rtype = dnsrp_pkg::RecTypeA;
        rdlen = ($urandom_range(9) < 7) ? 4 : $urandom_range(0, 8);
      end else if (rsel < 75) begin
        rtype = dnsrp_pkg::RecTypeAaaa;
        rdlen = ($urandom_range(9) < 7) ? 16 : $urandom_range(0, 20);
      end else begin
        rtype = 16'($urandom);
        rdlen = $urandom_range(0, 10);
      end
      put_answer(rtype, ttl, rdlen);
    end
    repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    if ($urandom_range(99) < 15) cut_message($urandom_range(1, msg_bytes.size()));
  endfunction

  // Offer one byte, idling first at the current rate, and wait for its acceptance
  task automatic send_byte(logic [7:0] b, logic last);
    dnsrp_pkg::in_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    item.data_byte = b;
    item.last_byte = last;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_message();
    int unsigned k;
    for (k = 0; k < msg_bytes.size(); k++) begin
      send_byte(msg_bytes[k], k == msg_bytes.size() - 1);
    end
    msgs_sent++;
    msg_bytes.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Messages that end inside or just after the header
  task automatic test_header_cases();
    add_byte(8'hFF);
    send_message();
    put16(16'h1234);
    put16(16'h8100);
    add_byte(8'h00);
    send_message();
    put_header(16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    add_byte(8'h00);
    add_byte(8'h00);
    send_message();
  endtask

  // Query instead of response, zero questions, and nonzero rcode
  task automatic test_bad_and_rcode();
    put_header(16'h0001, 16'h0000, 16'd1, 16'd0);
    put_question(8'd0);
    send_message();
    put_header(16'hABCD, 16'hFFF0, 16'd0, 16'd1);
    put_answer(dnsrp_pkg::RecTypeA, 32'd100, 4);
    send_message();
    put_header(16'h5A5A, 16'h800F, 16'd1, 16'd1);
    put_question(8'd0);
    put_answer(dnsrp_pkg::RecTypeA, 32'd7, 4);
    send_message();
  endtask

  // A, AAAA and other answers, reserved label type, trailing sections
  task automatic test_address_records();
    put_header(16'h0F0F, FlagsAnswer, 16'd1, 16'd3);
    put_question(8'h40);
    put_answer(dnsrp_pkg::RecTypeA, 32'hFFFF_FFFF, 4);
    put_answer(dnsrp_pkg::RecTypeAaaa, 32'd0, 16);
    put_answer(RecTypeCname, 32'h7FFF_FFFF, 3);
    add_byte(8'h00);
    add_byte(8'hFF);
    send_message();
  endtask

  // Short, long and empty rdata; message ends on the byte that closes a record
  task automatic test_rdata_lengths();
    put_header(16'h00FF, 16'h8400, 16'd2, 16'd4);
    put_question(8'hC0);
    put_question(8'hFF);
    put_answer(dnsrp_pkg::RecTypeA, 32'd1, 2);
    put_answer(dnsrp_pkg::RecTypeA, 32'd2, 6);
    put_answer(dnsrp_pkg::RecTypeAaaa, 32'd3, 20);
    put_answer(dnsrp_pkg::RecTypeAaaa, 32'd4, 0);
    send_message();
  endtask

  // Cut inside rdata and inside a question name
  task automatic test_truncation();
    put_header(16'h2468, FlagsAnswer, 16'd1, 16'd2);
    put_question(8'd0);
    put_answer(dnsrp_pkg::RecTypeA, 32'd50, 4);
    put_answer(dnsrp_pkg::RecTypeAaaa, 32'd60, 16);
    cut_message(msg_bytes.size() - 5);
    send_message();
    put_header(16'h1357, FlagsAnswer, 16'd1, 16'd1);
    add_byte(8'd5);
    add_byte(8'h61);
    add_byte(8'h62);
    send_message();
  endtask

  // Hold the output long enough that the queue fills and the input stalls
  task automatic test_output_hold();
    send_idle_pct = 0;
    stall_pct <= 0;
    hold_reqs <= hold_reqs + 1;
    put_header(16'hC0DE, FlagsAnswer, 16'd1, 16'd10);
    put_question(8'd0);
    repeat (10) put_answer(dnsrp_pkg::RecTypeA, $urandom, 0);
    send_message();
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall);
    int unsigned start;
    send_idle_pct = idle;
    stall_pct <= stall;
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) begin
      gen_random_message();
      send_message();
    end
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0);
    run_phase(83, 0);
    run_phase(0, 83);
    run_phase(7, 7);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_cases();
    test_bad_and_rcode();
    test_address_records();
    test_rdata_lengths();
    test_truncation();
    test_output_hold();
    test_random_traffic();

    // Drain what is still in flight
    in_valid <= 1'b0;
    stall_pct <= 0;
    while (records_due.size() != 0) @(posedge clk);
    repeat (EndDrain) @(posedge clk);

    $display("Sent %0d messages (%0d bytes) under four idle/stall mixes",
             msgs_sent, bytes_sent);
    $display("and one %0d-cycle hold; checked %0d address results, %0d summaries.",
             HoldCycles, addr_seen, summary_seen);
    if (mismatches == 0 && records_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
sv/dnsrp_pkg.sv
sv/dnsrp_parse.sv
sv/dnsrp_out_fifo.sv
sv/dns_response_record_parser_unit.sv
sim/tb_dns_response_record_parser_unit.sv
